// File: src/ray_triangle_intersect_defines.svh
// assertion macros shared by the ray-triangle intersection rtl
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RTI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant that holds at every clock edge out of reset
`define RTI_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// File: src/rti_pkg.sv
// shared constants, types and helpers of the ray-triangle intersection block
package rti_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int FB        = 16;          // fraction bits
  localparam int IOW       = 32;          // port width of a coordinate
  localparam int EW        = CW + 1;      // edge / offset width
  localparam int QW        = EW + EW + 1; // cross product width
  localparam int LB        = QW - EW;     // low slice of a split operand
  localparam int DW        = EW + QW + 3; // dot product width
  localparam int NW        = DW + FB;     // dividend width
  localparam int QB        = CW + 1;      // quotient bits kept
  localparam int LW        = NW + QB;     // divider compare width
  localparam int EPSW      = 40;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 40;
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;

  localparam logic [CW-1:0]   DIR_Z_RESET = CW'(1) << FB;
  localparam logic [EPSW-1:0] EPS_RESET   = EPSW'(281474977);

  typedef enum logic [CFG_IW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_DET_EPS  = 3'd6
  } cfg_idx_t;

  typedef logic signed [EW-1:0] ec_t;

  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
    logic [EPSW-1:0]    eps;
  } ray_t;

  typedef struct packed {
    logic          hit;
    logic          negt;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } mid_item_t;

  function automatic ec_t sx(input logic [CW-1:0] v);
    return EW'(signed'(v));
  endfunction

endpackage

// File: src/rti_queue.sv
// small register queue between the classifying front and the divider back
`include "ray_triangle_intersect_defines.svh"
module rti_queue import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mid_item_t din,
  output logic      full,
  input  logic      pop,
  output mid_item_t dout,
  output logic      empty
);

  mid_item_t         mem_r [MID_DEPTH];
  logic [MID_AW-1:0] wp_r, rp_r;
  logic [MID_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (MID_AW+1)'(MID_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  `RTI_ASSERT_IMPLIES(a_push_not_full, clk, rst_n, push, !full, "word pushed into full queue")
  `RTI_ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, pop, !empty, "word popped from empty queue")
  `RTI_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= (MID_AW+1)'(MID_DEPTH), "queue count past depth")

endmodule

// File: src/rti_front.sv
// front pipeline: edges, cross and dot products, hit classification
module rti_front import rti_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ray_t               ray,
  input  logic               in_valid,
  input  logic [2:0][IOW-1:0] v0,
  input  logic [2:0][IOW-1:0] v1,
  input  logic [2:0][IOW-1:0] v2,
  output logic               ready,
  input  logic               mid_full,
  output logic               mid_push,
  output mid_item_t          mid_item
);

  logic [8:1] v_r;
  logic       adv;

  assign adv      = !(v_r[8] && mid_full);
  assign ready    = adv;
  assign mid_push = adv && v_r[8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[7:1], in_valid};
    end
  end

  ec_t dv [3];
  ec_t ov [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = sx(ray.dir[i]);
      ov[i] = sx(ray.org[i]);
    end
  end

  // stage 1: edges and origin offset
  ec_t e1_1_r [3], e2_1_r [3], s_1_r [3];
  // stage 2: cross product terms
  ec_t e1_2_r [3], e2_2_r [3], s_2_r [3];
  logic signed [2*EW-1:0] pa_r [3], pb_r [3], qa_r [3], qb_r [3];
  // stage 3: cross products
  ec_t e1_3_r [3], e2_3_r [3], s_3_r [3];
  logic signed [QW-1:0] p_r [3], q_r [3];
  // stage 4: split partial products of the four dots
  logic signed [EW+LB:0]  lo_r [4][3];
  logic signed [2*EW-1:0] hi_r [4][3];
  // stage 5 and 6: terms and dot sums
  logic signed [DW-1:0] term_r [4][3];
  logic signed [DW-1:0] dot_r [4];
  // stage 7
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r, uv_r;
  // stage 8: sign corrected values
  logic [DW-1:0]        dabs_r, tabs_r;
  logic signed [DW-1:0] uc_r, vc_r, uvc_r;
  logic                 negt_r, dzero_r;

  ec_t                  lhs [4][3];
  logic signed [QW-1:0] rhs [4][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lhs[0][i] = e1_3_r[i]; rhs[0][i] = p_r[i];
      lhs[1][i] = s_3_r[i];  rhs[1][i] = p_r[i];
      lhs[2][i] = dv[i];     rhs[2][i] = q_r[i];
      lhs[3][i] = e2_3_r[i]; rhs[3][i] = q_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_1_r[i] <= sx(v1[i][CW-1:0]) - sx(v0[i][CW-1:0]);
        e2_1_r[i] <= sx(v2[i][CW-1:0]) - sx(v0[i][CW-1:0]);
        s_1_r[i]  <= ov[i] - sx(v0[i][CW-1:0]);
        e1_2_r[i] <= e1_1_r[i];
        e2_2_r[i] <= e2_1_r[i];
        s_2_r[i]  <= s_1_r[i];
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        s_3_r[i]  <= s_2_r[i];
        p_r[i]    <= QW'(pa_r[i]) - QW'(pb_r[i]);
        q_r[i]    <= QW'(qa_r[i]) - QW'(qb_r[i]);
      end
      // p = dir x e2, q = s x e1
      pa_r[0] <= dv[1] * e2_1_r[2];   pb_r[0] <= dv[2] * e2_1_r[1];
      pa_r[1] <= dv[2] * e2_1_r[0];   pb_r[1] <= dv[0] * e2_1_r[2];
      pa_r[2] <= dv[0] * e2_1_r[1];   pb_r[2] <= dv[1] * e2_1_r[0];
      qa_r[0] <= s_1_r[1] * e1_1_r[2]; qb_r[0] <= s_1_r[2] * e1_1_r[1];
      qa_r[1] <= s_1_r[2] * e1_1_r[0]; qb_r[1] <= s_1_r[0] * e1_1_r[2];
      qa_r[2] <= s_1_r[0] * e1_1_r[1]; qb_r[2] <= s_1_r[1] * e1_1_r[0];
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          lo_r[k][i]   <= lhs[k][i] * signed'({1'b0, rhs[k][i][LB-1:0]});
          hi_r[k][i]   <= lhs[k][i] * signed'(rhs[k][i][QW-1:LB]);
          term_r[k][i] <= (DW'(hi_r[k][i]) <<< LB) + DW'(lo_r[k][i]);
        end
        dot_r[k] <= term_r[k][0] + term_r[k][1] + term_r[k][2];
      end
      det_r <= dot_r[0];
      un_r  <= dot_r[1];
      vn_r  <= dot_r[2];
      tn_r  <= dot_r[3];
      uv_r  <= dot_r[1] + dot_r[2];
      dzero_r <= (det_r == '0);
      negt_r  <= tn_r[DW-1] ^ det_r[DW-1];
      dabs_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      tabs_r  <= tn_r[DW-1] ? DW'(-tn_r) : DW'(tn_r);
      uc_r    <= det_r[DW-1] ? -un_r : un_r;
      vc_r    <= det_r[DW-1] ? -vn_r : vn_r;
      uvc_r   <= det_r[DW-1] ? -uv_r : uv_r;
    end
  end

  logic hit;
  always_comb begin
    hit = !dzero_r && (dabs_r >= DW'(ray.eps))
       && !uc_r[DW-1] && (DW'(uc_r) <= dabs_r)
       && !vc_r[DW-1] && !uvc_r[DW-1] && (DW'(uvc_r) <= dabs_r);
    mid_item.hit  = hit;
    mid_item.negt = negt_r;
    mid_item.num  = NW'(tabs_r) << FB;
    mid_item.den  = dabs_r;
  end

endmodule

// File: src/rti_back.sv
// back pipeline: bit-per-stage divider for t, saturation and result queue
module rti_back import rti_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mid_empty,
  input  mid_item_t       mid_item,
  output logic            mid_pop,
  output logic            empty,
  input  logic            pop,
  output logic            out_hit,
  output logic [IOW-1:0]  out_t_hit
);

  logic [QB:0]   bv_r;
  logic          bh_r [QB+1];
  logic          bn_r [QB+1];
  logic          bo_r [QB+1];
  logic [NW-1:0] rem_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];

  logic oq_full, adv, oq_push;
  assign adv     = !(bv_r[QB] && oq_full);
  assign mid_pop = adv && !mid_empty;
  assign oq_push = adv && bv_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (adv) begin
      bv_r <= {bv_r[QB-1:0], mid_pop};
    end
  end

  // stage 0: quotient too large for the kept bits
  always_ff @(posedge clk) begin
    if (adv) begin
      bh_r[0]  <= mid_item.hit;
      bn_r[0]  <= mid_item.negt;
      bo_r[0]  <= LW'(mid_item.num) >= (LW'(mid_item.den) << QB);
      rem_r[0] <= mid_item.num;
      den_r[0] <= mid_item.den;
      quo_r[0] <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int SH = QB - k;
    logic [LW-1:0] dsh;
    logic          ge;
    logic [QB-1:0] quo_nxt;
    always_comb begin
      dsh          = LW'(den_r[k-1]) << SH;
      ge           = LW'(rem_r[k-1]) >= dsh;
      quo_nxt      = quo_r[k-1];
      quo_nxt[SH]  = ge;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        bh_r[k]  <= bh_r[k-1];
        bn_r[k]  <= bn_r[k-1];
        bo_r[k]  <= bo_r[k-1];
        den_r[k] <= den_r[k-1];
        rem_r[k] <= ge ? rem_r[k-1] - NW'(dsh) : rem_r[k-1];
        quo_r[k] <= quo_nxt;
      end
    end
  end

  localparam logic [QB-1:0] LIM = QB'(1) << (CW - 1);

  logic [QB-1:0]        tc;
  logic signed [QB-1:0] ts;
  logic [IOW-1:0]       t_res;
  always_comb begin
    if (bn_r[QB]) begin
      tc = (bo_r[QB] || quo_r[QB] > LIM) ? LIM : quo_r[QB];
      ts = -signed'(tc);
    end else begin
      tc = (bo_r[QB] || quo_r[QB] >= LIM) ? LIM - 1'b1 : quo_r[QB];
      ts = signed'(tc);
    end
    t_res = bh_r[QB] ? IOW'(ts) : '0;
  end

  // two word result queue
  logic           oq_hit_r [2];
  logic [IOW-1:0] oq_t_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_pop;

  assign oq_full   = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign do_pop    = pop && !empty;
  assign out_hit   = oq_hit_r[rp_r];
  assign out_t_hit = oq_t_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (oq_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !oq_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (oq_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_hit_r[wp_r] <= bh_r[QB];
      oq_t_r[wp_r]   <= t_res;
    end
  end

endmodule

// File: src/ray_triangle_intersect.sv
// top level of the fixed-point ray-triangle intersection block
// Moller-Trumbore test of one configured ray against a stream of triangles.
// One triangle word is taken per clock; results come out in order, one per
// triangle, hit flag plus Q16.16 distance t (saturated, zero on a miss).
// The result word reaches the output ports through these registers in order:
// eight front stages (edge subtract, two cross product stages, split 33x35
// and 33x33 dot partials, terms, sums, dot select, sign correction; classify
// is combinational), the four word queue, then 34 divider stages (range
// check, one quotient bit per stage; saturation is combinational) and the
// two word result queue. Throughput is one triangle per cycle; the front
// stalls only when the middle queue is full and the divider only when the
// result queue is full. Write the ray and epsilon only while no triangle is
// in flight; cfg_ready is always high.
`include "ray_triangle_intersect_defines.svh"
module ray_triangle_intersect import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [IOW-1:0]    in_v0_x,
  input  logic [IOW-1:0]    in_v0_y,
  input  logic [IOW-1:0]    in_v0_z,
  input  logic [IOW-1:0]    in_v1_x,
  input  logic [IOW-1:0]    in_v1_y,
  input  logic [IOW-1:0]    in_v1_z,
  input  logic [IOW-1:0]    in_v2_x,
  input  logic [IOW-1:0]    in_v2_y,
  input  logic [IOW-1:0]    in_v2_z,
  output logic              empty,
  input  logic              pop,
  output logic              out_hit,
  output logic [IOW-1:0]    out_t_hit,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  ray_t ray_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org <= '0;
      ray_r.dir <= {DIR_Z_RESET, CW'(0), CW'(0)};
      ray_r.eps <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: ray_r.org[0] <= cfg_data[CW-1:0];
        CFG_ORIGIN_Y: ray_r.org[1] <= cfg_data[CW-1:0];
        CFG_ORIGIN_Z: ray_r.org[2] <= cfg_data[CW-1:0];
        CFG_DIR_X:    ray_r.dir[0] <= cfg_data[CW-1:0];
        CFG_DIR_Y:    ray_r.dir[1] <= cfg_data[CW-1:0];
        CFG_DIR_Z:    ray_r.dir[2] <= cfg_data[CW-1:0];
        CFG_DET_EPS:  ray_r.eps    <= cfg_data[EPSW-1:0];
        default: ;
      endcase
    end
  end

  logic      front_ready, mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_in, mid_out;

  assign full = !front_ready;

  rti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .in_valid (push && front_ready),
    .v0       ({in_v0_z, in_v0_y, in_v0_x}),
    .v1       ({in_v1_z, in_v1_y, in_v1_x}),
    .v2       ({in_v2_z, in_v2_y, in_v2_x}),
    .ready    (front_ready),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  rti_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  rti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .out_hit   (out_hit),
    .out_t_hit (out_t_hit)
  );

  `RTI_ASSERT_IMPLIES(a_miss_zero_t, clk, rst_n, !empty && !out_hit, out_t_hit == '0, "miss word with nonzero t")

endmodule

// File: tb/ray_triangle_intersect_tb.sv
// self-checking testbench of the ray-triangle intersection block
module ray_triangle_intersect_tb import rti_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct {
    logic [31:0] v [9];
  } tri_t;

  typedef struct {
    logic        hit;
    logic [31:0] t_hit;
  } isect_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [IOW-1:0]    vtx [9];
  logic              empty;
  logic              pop = 1'b0;
  logic              out_hit;
  logic [IOW-1:0]    out_t_hit;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  logic [39:0] ray_reg [7];
  isect_t      isect_q [$];
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  bit          idle_en = 1'b1;

  initial begin
    for (int i = 0; i < 9; i++) vtx[i] = '0;
  end

  ray_triangle_intersect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_v0_x   (vtx[0]),
    .in_v0_y   (vtx[1]),
    .in_v0_z   (vtx[2]),
    .in_v1_x   (vtx[3]),
    .in_v1_y   (vtx[4]),
    .in_v1_z   (vtx[5]),
    .in_v2_x   (vtx[6]),
    .in_v2_y   (vtx[7]),
    .in_v2_z   (vtx[8]),
    .empty     (empty),
    .pop       (pop),
    .out_hit   (out_hit),
    .out_t_hit (out_t_hit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot3(input vec3_t a, input vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // exact moller-trumbore on wide integers, u and v kept as numerators
  function automatic isect_t trace_ray(input tri_t tr);
    vec3_t  o, d, v0, e1, e2, s, p, q;
    wide_t  det, dabs, un, vn, tn;
    logic [127:0] tabs, tq;
    logic   negt;
    isect_t r;
    r.hit = 1'b0;
    r.t_hit = '0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = $signed(ray_reg[i][31:0]);
      d[i]  = $signed(ray_reg[3+i][31:0]);
      v0[i] = $signed(tr.v[i]);
      e1[i] = wide_t'($signed(tr.v[3+i])) - v0[i];
      e2[i] = wide_t'($signed(tr.v[6+i])) - v0[i];
      s[i]  = o[i] - v0[i];
    end
    cross3(d, e2, p);
    det = dot3(e1, p);
    dabs = det < 0 ? -det : det;
    if (det == 0 || dabs < wide_t'({88'd0, ray_reg[CFG_DET_EPS]})) return r;
    un = dot3(s, p);
    cross3(s, e1, q);
    vn = dot3(d, q);
    tn = dot3(e2, q);
    if (det < 0) begin
      un = -un;
      vn = -vn;
    end
    if (un < 0 || un > dabs) return r;
    if (vn < 0 || un + vn > dabs) return r;
    negt = (tn < 0) != (det < 0);
    tabs = tn < 0 ? -tn : tn;
    tq = (tabs << FB) / 128'(dabs);
    if (negt) begin
      if (tq > 128'h8000_0000) tq = 128'h8000_0000;
      r.t_hit = -tq[31:0];
    end else begin
      if (tq >= 128'h8000_0000) tq = 128'h7fff_ffff;
      r.t_hit = tq[31:0];
    end
    r.hit = 1'b1;
    return r;
  endfunction

  // result side: random stalls, compare against oldest prediction
  always @(posedge clk) begin
    pop <= idle_en ? ($urandom_range(99) >= 19) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (isect_q.size() == 0) begin
        $error("result word with no prediction waiting");
        err_cnt++;
      end else begin
        isect_t e;
        e = isect_q.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0b actual %0b", e.hit, out_hit);
          err_cnt++;
        end
        if (out_t_hit !== e.t_hit) begin
          $error("t_hit: expected %h actual %h", e.t_hit, out_t_hit);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("FAIL ray_triangle_intersect");
      $finish;
    end
  end

  task automatic send_tri(input tri_t tr);
    if (idle_en && $urandom_range(99) < 19) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1'b1;
    for (int i = 0; i < 9; i++) vtx[i] <= tr.v[i];
    @(posedge clk);
    while (full) @(posedge clk);
    isect_q.push_back(trace_ray(tr));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (isect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ray_reg[idx] = (idx == CFG_DET_EPS) ? val : {8'd0, val[31:0]};
    @(posedge clk);
  endtask

  function automatic logic [31:0] srnd(input int mag);
    return 32'(int'($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic tri_t mk_tri(input logic [31:0] a [9]);
    tri_t tr;
    tr.v = a;
    return tr;
  endfunction

  // flat triangle in a z plane around (cx, cy), radius r
  function automatic tri_t flat_tri(input logic [31:0] cx, cy, z, r);
    return mk_tri('{cx - r, cy - r, z, cx + r, cy - r, z, cx, cy + r, z});
  endfunction

  function automatic tri_t noise_tri();
    tri_t tr;
    for (int i = 0; i < 9; i++) tr.v[i] = $urandom;
    return tr;
  endfunction

  // triangle scattered around a point on the configured ray
  function automatic tri_t aimed_tri();
    tri_t tr;
    logic signed [63:0] t, c;
    t = $signed(srnd(1 << 18));
    for (int k = 0; k < 3; k++) begin
      c = $signed(ray_reg[k][31:0]) + ((t * $signed(ray_reg[3+k][31:0])) >>> FB);
      for (int j = 0; j < 3; j++) tr.v[3*j+k] = 32'(c) + srnd(1 << 18);
    end
    return tr;
  endfunction

  task automatic test_reset_ray();
    send_tri(flat_tri(32'h0, 32'h0, 32'h0005_0000, 32'h0001_0000));
    send_tri(flat_tri(32'h0, 32'h0, 32'hfffb_0000, 32'h0001_0000));
    send_tri(flat_tri(32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0001_0000));
    // ray through a vertex and through a point on an edge, borders are inclusive
    send_tri(mk_tri('{0, 0, 32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000,
                      0, 32'h0002_0000, 32'h0001_0000}));
    send_tri(mk_tri('{32'hffff_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000,
                      0, 32'h0001_0000, 32'h0001_0000}));
    // degenerate triangle, det is zero
    send_tri(mk_tri('{0, 0, 5, 0, 0, 5, 0, 0, 5}));
    send_tri(mk_tri('{1, 1, 1, 2, 2, 2, 3, 3, 3}));
    send_tri(mk_tri('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff}));
    send_tri(mk_tri('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff}));
    send_tri(mk_tri('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                      32'hffff_ffff, 0, 32'hffff_ffff}));
    // hold the sender until every word has come back
    wait_idle();
    send_tri(flat_tri(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001));
    send_tri(flat_tri(32'h0, 32'h0, 32'h0000_0000, 32'h0000_0004));
    wait_idle();
  endtask

  task automatic test_epsilon();
    write_reg(CFG_DET_EPS, 40'd0);
    send_tri(mk_tri('{0, 0, 5, 0, 0, 5, 0, 0, 5}));
    send_tri(flat_tri(32'h0, 32'h0, 32'h0001_0000, 32'h0000_0001));
    wait_idle();
    write_reg(CFG_DET_EPS, 40'hff_ffff_ffff);
    send_tri(flat_tri(32'h0, 32'h0, 32'h0005_0000, 32'h0001_0000));
    send_tri(flat_tri(32'h0, 32'h0, 32'h0005_0000, 32'h4000_0000));
    wait_idle();
    write_reg(CFG_DET_EPS, 40'd281474977);
  endtask

  task automatic test_saturation();
    write_reg(CFG_ORIGIN_Z, 32'h8000_0000);
    send_tri(flat_tri(32'h0, 32'h0, 32'h7fff_ffff, 32'h1000_0000));
    send_tri(flat_tri(32'h0, 32'h0, 32'h0000_0000, 32'h1000_0000));
    wait_idle();
    write_reg(CFG_ORIGIN_Z, 32'h7fff_ffff);
    send_tri(flat_tri(32'h0, 32'h0, 32'h8000_0000, 32'h1000_0000));
    wait_idle();
    write_reg(CFG_ORIGIN_Z, 32'h0);
    write_reg(CFG_DIR_Z, 32'h0000_0001);
    send_tri(flat_tri(32'h0, 32'h0, 32'h0100_0000, 32'h0001_0000));
    send_tri(flat_tri(32'h0, 32'h0, 32'hff00_0000, 32'h0001_0000));
    wait_idle();
  endtask

  task automatic test_random_rays();
    for (int ph = 0; ph < 7; ph++) begin
      idle_en = (ph != 3);
      if (ph == 6) begin
        for (int k = 0; k < 6; k++) write_reg(cfg_idx_t'(k), {8'd0, $urandom});
        write_reg(CFG_DET_EPS, {$urandom, 8'(($urandom))});
      end else begin
        for (int k = 0; k < 3; k++) write_reg(cfg_idx_t'(k), srnd(1 << 20));
        for (int k = 3; k < 6; k++) write_reg(cfg_idx_t'(k), srnd(1 << 17));
        write_reg(CFG_DET_EPS, (ph % 2) ? 40'(($urandom_range(1000))) : 40'd281474977);
      end
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(99) < 80) send_tri(aimed_tri());
        else send_tri(noise_tri());
      end
      wait_idle();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    ray_reg[CFG_ORIGIN_X] = '0;
    ray_reg[CFG_ORIGIN_Y] = '0;
    ray_reg[CFG_ORIGIN_Z] = '0;
    ray_reg[CFG_DIR_X]    = '0;
    ray_reg[CFG_DIR_Y]    = '0;
    ray_reg[CFG_DIR_Z]    = {8'd0, DIR_Z_RESET};
    ray_reg[CFG_DET_EPS]  = EPS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_ray();
    test_epsilon();
    test_saturation();
    test_random_rays();
    if (err_cnt == 0) begin
      $display("PASS ray_triangle_intersect");
    end else begin
      $display("FAIL ray_triangle_intersect");
    end
    $finish;
  end

endmodule
